@@ hw/rtl/hhp_pkg.sv @@
// shared constants, codes and helpers for the hunk header parser
package hhp_pkg;

	// coordinate width default and fixed port widths
	localparam int COORD_WIDTH_DEF = 32;
	localparam int CFG_WIDTH       = 32;
	localparam int OUT_WIDTH       = 32;

	// character codes
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// result verdicts
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_NOT = 2'd1,
		ST_MAL = 2'd2
	} status_t;

	// parser phases
	typedef enum logic [3:0] {
		PH_AT1,
		PH_AT2,
		PH_SEP,
		PH_MINUS,
		PH_OLD_OFF,
		PH_OLD_AFTER,
		PH_OLD_CNT,
		PH_OLD_CNT_AFTER,
		PH_NEW_OFF,
		PH_NEW_AFTER,
		PH_NEW_CNT,
		PH_NEW_CNT_AFTER,
		PH_DONE
	} phase_t;

	// low output bits of a zero-extended coordinate
	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [63:0] v);
		return v[OUT_WIDTH-1:0];
	endfunction

endpackage

@@ hw/rtl/hunk_header_parser_unit.sv @@
// hunk header parser: byte-stream parser for unified diff @@ lines
// path: an accepted word is held in the input register stage, and a line-end word then loads the result register
// throughput: one word per cycle; a line-end word waits only while a result is stalled
// reset: arst_n clears the parser to the start of a line, sets the limit register
//   to all ones and leaves the result register empty
module hunk_header_parser_unit #(
	parameter int COORD_WIDTH = hhp_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// limit register write
	input  logic                         write_enable,
	input  logic [hhp_pkg::CFG_WIDTH-1:0] write_data,
	// incoming bytes
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         has_byte,
	input  logic                         line_end,
	// parse results
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [1:0]                   status,
	output logic [hhp_pkg::OUT_WIDTH-1:0] old_offset,
	output logic [hhp_pkg::OUT_WIDTH-1:0] old_count,
	output logic [hhp_pkg::OUT_WIDTH-1:0] new_side_offset,
	output logic [hhp_pkg::OUT_WIDTH-1:0] new_side_count
);

	localparam int AW = COORD_WIDTH + 4;   // room for acc * 10 + digit

	// limit reset: all ones over the low 32 bits, cut to the coordinate width
	localparam logic [63:0] LIMIT_RST64 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [COORD_WIDTH-1:0] LIMIT_RST = LIMIT_RST64[COORD_WIDTH-1:0];
	localparam logic [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);

	// limit register
	logic [COORD_WIDTH-1:0] max_coord_q;
	logic [63:0]            wdata_ext;

	assign wdata_ext = 64'(write_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_coord_q <= LIMIT_RST;
		end else if (write_enable) begin
			max_coord_q <= wdata_ext[COORD_WIDTH-1:0];
		end
	end

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       end_s1;
	logic       item_accept;
	logic       go_s1;
	logic       res_free;

	// the result slot frees up when it is empty or being taken this cycle
	assign res_free    = !result_valid || !result_stall;
	// a word without a line end never needs the result slot
	assign go_s1       = valid_s1 && (!end_s1 || res_free);
	assign item_stall  = valid_s1 && !go_s1;
	assign item_accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			byte_s1 <= data_byte;
			has_s1  <= has_byte;
			end_s1  <= line_end;
		end
	end

	// parser state
	hhp_pkg::phase_t        phase_q;
	logic [COORD_WIDTH-1:0] acc_q;
	logic                   saw_q;
	hhp_pkg::status_t       verdict_q;
	logic [COORD_WIDTH-1:0] old_off_q;
	logic [COORD_WIDTH-1:0] old_cnt_q;
	logic [COORD_WIDTH-1:0] new_off_q;
	logic [COORD_WIDTH-1:0] new_cnt_q;

	// state after the byte of this word
	hhp_pkg::phase_t        phase_b;
	logic [COORD_WIDTH-1:0] acc_b;
	logic                   saw_b;
	hhp_pkg::status_t       verdict_b;
	logic [COORD_WIDTH-1:0] old_off_b;
	logic [COORD_WIDTH-1:0] old_cnt_b;
	logic [COORD_WIDTH-1:0] new_off_b;
	logic [COORD_WIDTH-1:0] new_cnt_b;

	// digit append: acc * 10 + d, checked against the limit in the wide domain
	logic          is_digit;
	logic          is_blank;
	logic [AW-1:0] acc_wide;
	logic [AW-1:0] acc_next_wide;
	logic          over_limit;

	assign is_digit = byte_s1 inside {[hhp_pkg::CH_ZERO:hhp_pkg::CH_NINE]};
	assign is_blank = byte_s1 inside {hhp_pkg::CH_SPACE, hhp_pkg::CH_TAB};
	assign acc_wide = AW'(acc_q);
	assign acc_next_wide = (acc_wide << 3) + (acc_wide << 1)
		+ AW'(byte_s1 - hhp_pkg::CH_ZERO);
	// acc > (max - d) / 10 or d > max both reduce to acc * 10 + d > max
	assign over_limit = acc_next_wide > AW'(max_coord_q);

	// byte step
	hhp_pkg::phase_t aph;
	logic            do_after;
	logic            on_new;

	always_comb begin
		phase_b   = phase_q;
		acc_b     = acc_q;
		saw_b     = saw_q;
		verdict_b = verdict_q;
		old_off_b = old_off_q;
		old_cnt_b = old_cnt_q;
		new_off_b = new_off_q;
		new_cnt_b = new_cnt_q;
		aph       = phase_q;
		do_after  = 1'b0;
		on_new    = 1'b0;

		if (has_s1) begin
			case (phase_q)
				hhp_pkg::PH_AT1: begin
					if (byte_s1 == hhp_pkg::CH_AT) begin
						phase_b = hhp_pkg::PH_AT2;
					end else begin
						phase_b   = hhp_pkg::PH_DONE;
						verdict_b = hhp_pkg::ST_NOT;
					end
				end
				hhp_pkg::PH_AT2: begin
					if (byte_s1 == hhp_pkg::CH_AT) begin
						phase_b = hhp_pkg::PH_SEP;
					end else begin
						phase_b   = hhp_pkg::PH_DONE;
						verdict_b = hhp_pkg::ST_NOT;
					end
				end
				hhp_pkg::PH_SEP: begin
					if (is_blank) begin
						phase_b = hhp_pkg::PH_MINUS;
					end else begin
						phase_b   = hhp_pkg::PH_DONE;
						verdict_b = hhp_pkg::ST_NOT;
					end
				end
				hhp_pkg::PH_MINUS: begin
					if (byte_s1 == hhp_pkg::CH_MINUS) begin
						phase_b = hhp_pkg::PH_OLD_OFF;
						acc_b   = '0;
						saw_b   = 1'b0;
					end else if (!is_blank) begin
						phase_b   = hhp_pkg::PH_DONE;
						verdict_b = hhp_pkg::ST_NOT;
					end
				end
				hhp_pkg::PH_OLD_OFF, hhp_pkg::PH_OLD_CNT,
				hhp_pkg::PH_NEW_OFF, hhp_pkg::PH_NEW_CNT: begin
					if (is_digit) begin
						if (over_limit) begin
							phase_b   = hhp_pkg::PH_DONE;
							verdict_b = hhp_pkg::ST_MAL;
						end else begin
							acc_b = acc_next_wide[COORD_WIDTH-1:0];
							saw_b = 1'b1;
						end
					end else if (!saw_q) begin
						if (!is_blank) begin
							phase_b   = hhp_pkg::PH_DONE;
							verdict_b = hhp_pkg::ST_MAL;
						end
					end else begin
						// number closes; the same byte then goes to the after-side check
						case (phase_q)
							hhp_pkg::PH_OLD_OFF: begin
								old_off_b = acc_q;
								aph       = hhp_pkg::PH_OLD_AFTER;
							end
							hhp_pkg::PH_OLD_CNT: begin
								old_cnt_b = acc_q;
								aph       = hhp_pkg::PH_OLD_CNT_AFTER;
							end
							hhp_pkg::PH_NEW_OFF: begin
								new_off_b = acc_q;
								aph       = hhp_pkg::PH_NEW_AFTER;
							end
							default: begin
								new_cnt_b = acc_q;
								aph       = hhp_pkg::PH_NEW_CNT_AFTER;
							end
						endcase
						phase_b  = aph;
						saw_b    = 1'b0;
						do_after = 1'b1;
					end
				end
				hhp_pkg::PH_OLD_AFTER, hhp_pkg::PH_OLD_CNT_AFTER,
				hhp_pkg::PH_NEW_AFTER, hhp_pkg::PH_NEW_CNT_AFTER: begin
					do_after = 1'b1;
				end
				default: begin
				end
			endcase

			// what may follow a finished side
			if (do_after) begin
				on_new = (aph == hhp_pkg::PH_NEW_AFTER) || (aph == hhp_pkg::PH_NEW_CNT_AFTER);
				if (is_blank) begin
					// blanks are skipped
				end else if (byte_s1 == hhp_pkg::CH_COMMA && aph == hhp_pkg::PH_OLD_AFTER) begin
					phase_b = hhp_pkg::PH_OLD_CNT;
					acc_b   = '0;
					saw_b   = 1'b0;
				end else if (byte_s1 == hhp_pkg::CH_COMMA && aph == hhp_pkg::PH_NEW_AFTER) begin
					phase_b = hhp_pkg::PH_NEW_CNT;
					acc_b   = '0;
					saw_b   = 1'b0;
				end else if (byte_s1 == hhp_pkg::CH_PLUS && !on_new) begin
					phase_b = hhp_pkg::PH_NEW_OFF;
					acc_b   = '0;
					saw_b   = 1'b0;
				end else if (on_new && (byte_s1 == hhp_pkg::CH_AT
						|| byte_s1 == hhp_pkg::CH_CR || byte_s1 == hhp_pkg::CH_LF)) begin
					phase_b   = hhp_pkg::PH_DONE;
					verdict_b = hhp_pkg::ST_OK;
				end else begin
					phase_b   = hhp_pkg::PH_DONE;
					verdict_b = hhp_pkg::ST_MAL;
				end
			end
		end
	end

	// line end verdict, taken from the state after the byte
	hhp_pkg::status_t       end_status;
	logic [COORD_WIDTH-1:0] end_new_off;
	logic [COORD_WIDTH-1:0] end_new_cnt;

	always_comb begin
		end_new_off = new_off_b;
		end_new_cnt = new_cnt_b;
		case (phase_b)
			hhp_pkg::PH_AT1, hhp_pkg::PH_AT2, hhp_pkg::PH_SEP, hhp_pkg::PH_MINUS: begin
				end_status = hhp_pkg::ST_NOT;
			end
			hhp_pkg::PH_NEW_OFF: begin
				// line may end right after the new offset digits
				end_status  = saw_b ? hhp_pkg::ST_OK : hhp_pkg::ST_MAL;
				end_new_off = acc_b;
			end
			hhp_pkg::PH_NEW_CNT: begin
				end_status  = saw_b ? hhp_pkg::ST_OK : hhp_pkg::ST_MAL;
				end_new_cnt = acc_b;
			end
			hhp_pkg::PH_NEW_AFTER, hhp_pkg::PH_NEW_CNT_AFTER: begin
				end_status = hhp_pkg::ST_OK;
			end
			hhp_pkg::PH_DONE: begin
				end_status = verdict_b;
			end
			default: begin
				end_status = hhp_pkg::ST_MAL;
			end
		endcase
	end

	// state update; a line end restores the start-of-line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hhp_pkg::PH_AT1;
			acc_q     <= '0;
			saw_q     <= 1'b0;
			verdict_q <= hhp_pkg::ST_OK;
			old_off_q <= '0;
			old_cnt_q <= COORD_ONE;
			new_off_q <= '0;
			new_cnt_q <= COORD_ONE;
		end else if (go_s1) begin
			if (end_s1) begin
				phase_q   <= hhp_pkg::PH_AT1;
				acc_q     <= '0;
				saw_q     <= 1'b0;
				verdict_q <= hhp_pkg::ST_OK;
				old_off_q <= '0;
				old_cnt_q <= COORD_ONE;
				new_off_q <= '0;
				new_cnt_q <= COORD_ONE;
			end else begin
				phase_q   <= phase_b;
				acc_q     <= acc_b;
				saw_q     <= saw_b;
				verdict_q <= verdict_b;
				old_off_q <= old_off_b;
				old_cnt_q <= old_cnt_b;
				new_off_q <= new_off_b;
				new_cnt_q <= new_cnt_b;
			end
		end
	end

	// result register
	logic res_load;
	logic res_ok;

	assign res_load = go_s1 && end_s1;
	assign res_ok   = end_status == hhp_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// coordinates read as zero unless the header parsed cleanly
	always_ff @(posedge clk) begin
		if (res_load) begin
			status          <= 2'(end_status);
			old_offset      <= res_ok ? hhp_pkg::to_out(64'(old_off_b)) : '0;
			old_count       <= res_ok ? hhp_pkg::to_out(64'(old_cnt_b)) : '0;
			new_side_offset <= res_ok ? hhp_pkg::to_out(64'(end_new_off)) : '0;
			new_side_count  <= res_ok ? hhp_pkg::to_out(64'(end_new_cnt)) : '0;
		end
	end

endmodule

@@ bench/hunk_header_parser_unit_tb.sv @@
// testbench for the hunk header parser: scripted and random diff lines checked against a predictor
module hunk_header_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASES       = 8;
	localparam int WORDS_PER_PHASE = 145;

	// one word on the byte channel
	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       fin;
	} line_word_t;

	// one parsed line as the block should report it
	typedef struct {
		hhp_pkg::status_t st;
		logic [31:0]      oo;
		logic [31:0]      oc;
		logic [31:0]      no;
		logic [31:0]      nc;
	} hunk_result_t;

	// limit settings, one entry per phase, and idle mixes that repeat every four phases
	logic [31:0] limit_plan [PHASES] = '{32'hFFFF_FFFF, 32'd9, 32'd3, 32'd65535,
		32'd1000000, 32'hFFFF_FFFE, 32'd9, 32'hFFFF_FFFF};
	int send_gap_plan [4] = '{0, 48, 0, 29};
	int stall_plan [4]    = '{0, 0, 48, 29};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        write_enable = 1'b0;
	logic [31:0] write_data   = '0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [7:0]  data_byte    = '0;
	logic        has_byte     = 1'b0;
	logic        line_end     = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] old_offset;
	logic [31:0] old_count;
	logic [31:0] new_side_offset;
	logic [31:0] new_side_count;

	// stimulus and scoreboard stores
	line_word_t   pending_words [$];
	hunk_result_t expected_hunks [$];
	logic [7:0]   text_buf [$];
	line_word_t   word_on_port;

	int send_gap_pct  = 0;
	int stall_pct     = 0;
	int words_planned = 0;
	int words_taken   = 0;
	int lines_checked = 0;
	int mismatch_count = 0;
	int cycle_count   = 0;

	// predictor copy of the parser state and the limit register
	hhp_pkg::phase_t  pr_phase;
	logic [31:0]      pr_acc;
	bit               pr_digit;
	hhp_pkg::status_t pr_verdict;
	logic [31:0]      pr_old_off;
	logic [31:0]      pr_old_cnt;
	logic [31:0]      pr_new_off;
	logic [31:0]      pr_new_cnt;
	logic [31:0]      coord_limit = 32'hFFFF_FFFF;

	hunk_header_parser_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.write_enable    (write_enable),
		.write_data      (write_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.data_byte       (data_byte),
		.has_byte        (has_byte),
		.line_end        (line_end),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.old_offset      (old_offset),
		.old_count       (old_count),
		.new_side_offset (new_side_offset),
		.new_side_count  (new_side_count)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic bit is_blank(logic [7:0] c);
		return c == hhp_pkg::CH_SPACE || c == hhp_pkg::CH_TAB;
	endfunction

	// back to the start of a line, counts default to one
	task automatic clear_line();
		pr_phase   = hhp_pkg::PH_AT1;
		pr_acc     = '0;
		pr_digit   = 1'b0;
		pr_verdict = hhp_pkg::ST_OK;
		pr_old_off = '0;
		pr_old_cnt = 32'd1;
		pr_new_off = '0;
		pr_new_cnt = 32'd1;
	endtask

	// verdict is fixed, rest of the line is ignored
	task automatic settle(hhp_pkg::status_t s);
		pr_verdict = s;
		pr_phase   = hhp_pkg::PH_DONE;
	endtask

	task automatic open_number(hhp_pkg::phase_t p);
		pr_phase = p;
		pr_acc   = '0;
		pr_digit = 1'b0;
	endtask

	// store the accumulated number in the slot of the current phase
	task automatic close_number();
		case (pr_phase)
			hhp_pkg::PH_OLD_OFF: begin
				pr_old_off = pr_acc;
				pr_phase   = hhp_pkg::PH_OLD_AFTER;
			end
			hhp_pkg::PH_OLD_CNT: begin
				pr_old_cnt = pr_acc;
				pr_phase   = hhp_pkg::PH_OLD_CNT_AFTER;
			end
			hhp_pkg::PH_NEW_OFF: begin
				pr_new_off = pr_acc;
				pr_phase   = hhp_pkg::PH_NEW_AFTER;
			end
			default: begin
				pr_new_cnt = pr_acc;
				pr_phase   = hhp_pkg::PH_NEW_CNT_AFTER;
			end
		endcase
		pr_digit = 1'b0;
	endtask

	// byte seen after a complete number: comma, plus, terminator or junk
	task automatic after_side(logic [7:0] c);
		bit on_new;
		on_new = pr_phase == hhp_pkg::PH_NEW_AFTER || pr_phase == hhp_pkg::PH_NEW_CNT_AFTER;
		if (!is_blank(c)) begin
			if (c == hhp_pkg::CH_COMMA && pr_phase == hhp_pkg::PH_OLD_AFTER)
				open_number(hhp_pkg::PH_OLD_CNT);
			else if (c == hhp_pkg::CH_COMMA && pr_phase == hhp_pkg::PH_NEW_AFTER)
				open_number(hhp_pkg::PH_NEW_CNT);
			else if (c == hhp_pkg::CH_PLUS && !on_new)
				open_number(hhp_pkg::PH_NEW_OFF);
			else if (on_new && (c == hhp_pkg::CH_AT || c == hhp_pkg::CH_CR
					|| c == hhp_pkg::CH_LF))
				settle(hhp_pkg::ST_OK);
			else
				settle(hhp_pkg::ST_MAL);
		end
	endtask

	task automatic parse_byte(logic [7:0] c);
		logic [31:0] d;
		case (pr_phase)
			hhp_pkg::PH_AT1:
				if (c == hhp_pkg::CH_AT) pr_phase = hhp_pkg::PH_AT2;
				else settle(hhp_pkg::ST_NOT);
			hhp_pkg::PH_AT2:
				if (c == hhp_pkg::CH_AT) pr_phase = hhp_pkg::PH_SEP;
				else settle(hhp_pkg::ST_NOT);
			hhp_pkg::PH_SEP:
				if (is_blank(c)) pr_phase = hhp_pkg::PH_MINUS;
				else settle(hhp_pkg::ST_NOT);
			hhp_pkg::PH_MINUS:
				if (c == hhp_pkg::CH_MINUS) open_number(hhp_pkg::PH_OLD_OFF);
				else if (!is_blank(c)) settle(hhp_pkg::ST_NOT);
			hhp_pkg::PH_OLD_OFF, hhp_pkg::PH_OLD_CNT,
			hhp_pkg::PH_NEW_OFF, hhp_pkg::PH_NEW_CNT: begin
				if (c >= hhp_pkg::CH_ZERO && c <= hhp_pkg::CH_NINE) begin
					d = 32'(c) - 32'(hhp_pkg::CH_ZERO);
					// malformed as soon as one more digit would pass the limit
					if (d > coord_limit || pr_acc > (coord_limit - d) / 32'd10) begin
						settle(hhp_pkg::ST_MAL);
					end else begin
						pr_acc   = pr_acc * 32'd10 + d;
						pr_digit = 1'b1;
					end
				end else if (!pr_digit) begin
					if (!is_blank(c)) settle(hhp_pkg::ST_MAL);
				end else begin
					close_number();
					after_side(c);
				end
			end
			hhp_pkg::PH_OLD_AFTER, hhp_pkg::PH_OLD_CNT_AFTER,
			hhp_pkg::PH_NEW_AFTER, hhp_pkg::PH_NEW_CNT_AFTER:
				after_side(c);
			default: ;
		endcase
	endtask

	// verdict when the line ends in the current phase
	task automatic end_verdict(output hhp_pkg::status_t s);
		case (pr_phase)
			hhp_pkg::PH_AT1, hhp_pkg::PH_AT2, hhp_pkg::PH_SEP, hhp_pkg::PH_MINUS:
				s = hhp_pkg::ST_NOT;
			hhp_pkg::PH_NEW_OFF, hhp_pkg::PH_NEW_CNT: begin
				if (!pr_digit) begin
					s = hhp_pkg::ST_MAL;
				end else begin
					close_number();
					s = hhp_pkg::ST_OK;
				end
			end
			hhp_pkg::PH_NEW_AFTER, hhp_pkg::PH_NEW_CNT_AFTER:
				s = hhp_pkg::ST_OK;
			hhp_pkg::PH_DONE:
				s = pr_verdict;
			default:
				s = hhp_pkg::ST_MAL;
		endcase
	endtask

	// feed one accepted word, queue the line result when the word ends the line
	task automatic predict_hunk(line_word_t w);
		hhp_pkg::status_t s;
		hunk_result_t     r;
		if (w.has) parse_byte(w.data);
		if (w.fin) begin
			end_verdict(s);
			r.st = s;
			if (s == hhp_pkg::ST_OK) begin
				r.oo = pr_old_off;
				r.oc = pr_old_cnt;
				r.no = pr_new_off;
				r.nc = pr_new_cnt;
			end else begin
				r.oo = '0;
				r.oc = '0;
				r.no = '0;
				r.nc = '0;
			end
			expected_hunks.push_back(r);
			clear_line();
		end
	endtask

	// ---------------------------------------------------------------
	// line builders
	// ---------------------------------------------------------------

	task automatic queue_word(logic [7:0] data, logic has, logic fin);
		line_word_t w;
		w.data = data;
		w.has  = has;
		w.fin  = fin;
		pending_words.push_back(w);
		if (has || fin) words_planned++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic add_blanks(int n_max);
		int n;
		n = $urandom_range(n_max);
		repeat (n) text_buf.push_back($urandom_range(1) ? hhp_pkg::CH_SPACE : hhp_pkg::CH_TAB);
	endtask

	task automatic add_number(longint unsigned v);
		logic [7:0] digs [$];
		if (v == 0) digs.push_back(hhp_pkg::CH_ZERO);
		while (v != 0) begin
			digs.push_front(8'(v % 10) + hhp_pkg::CH_ZERO);
			v = v / 10;
		end
		foreach (digs[i]) text_buf.push_back(digs[i]);
	endtask

	// small numbers half the time, otherwise the limit edges and huge values
	function automatic longint unsigned pick_coord();
		case ($urandom_range(11))
			0: return 64'(coord_limit);
			1: return 64'(coord_limit) + 64'd1;
			2: return 64'hFFFF_FFFF;
			3: return 64'h1_0000_0000;
			4: return 64'd0;
			5: return 64'($urandom);
			6: return {$urandom, $urandom};
			7: return 64'($urandom_range(9));
			default: return 64'($urandom_range(999));
		endcase
	endfunction

	// a well-formed header with random numbers, blanks and tail
	task automatic build_header();
		add_text("@@");
		text_buf.push_back($urandom_range(1) ? hhp_pkg::CH_SPACE : hhp_pkg::CH_TAB);
		add_blanks(2);
		add_text("-");
		add_blanks(1);
		add_number(pick_coord());
		add_blanks(1);
		if ($urandom_range(2) != 0) begin
			add_text(",");
			add_blanks(1);
			add_number(pick_coord());
			add_blanks(1);
		end
		add_text("+");
		add_blanks(1);
		add_number(pick_coord());
		add_blanks(1);
		if ($urandom_range(2) != 0) begin
			add_text(",");
			add_blanks(1);
			add_number(pick_coord());
			add_blanks(1);
		end
		case ($urandom_range(4))
			0: ;
			1: begin
				add_text(" @@");
				repeat ($urandom_range(6)) text_buf.push_back(8'($urandom));
			end
			2: add_text("\r\n");
			3: add_text("\n");
			default: add_text("@@ x");
		endcase
	endtask

	// one byte replaced, dropped or added
	task automatic damage_line();
		string      pool = "@-+, \t\r\n09x";
		int         pos;
		logic [7:0] c;
		if (text_buf.size() != 0) begin
			pos = $urandom_range(text_buf.size() - 1);
			c = ($urandom_range(3) == 0) ? 8'($urandom) : pool[$urandom_range(pool.len() - 1)];
			case ($urandom_range(2))
				0: text_buf[pos] = c;
				1: text_buf.delete(pos);
				default: text_buf.insert(pos, c);
			endcase
		end
	endtask

	task automatic build_random_line();
		int kind;
		int cut;
		kind = $urandom_range(99);
		if (kind < 75) begin
			build_header();
			if ($urandom_range(3) == 0) damage_line();
		end else if (kind < 90) begin
			// noise, sometimes behind a valid prefix
			if ($urandom_range(1)) add_text("@@");
			repeat ($urandom_range(16)) text_buf.push_back(8'($urandom));
		end else begin
			// header cut short
			build_header();
			cut = $urandom_range(text_buf.size());
			while (text_buf.size() > cut) void'(text_buf.pop_back());
		end
	endtask

	// turn the text buffer into words; the end comes on the last byte or apart
	task automatic emit_line(bit end_apart);
		for (int i = 0; i < text_buf.size(); i++) begin
			if ($urandom_range(15) == 0) queue_word(8'($urandom), 1'b0, 1'b0);
			queue_word(text_buf[i], 1'b1, !end_apart && i == text_buf.size() - 1);
		end
		if (end_apart || text_buf.size() == 0) queue_word(8'($urandom), 1'b0, 1'b1);
		text_buf.delete();
	endtask

	task automatic scripted_line(string s, bit end_apart);
		add_text(s);
		emit_line(end_apart);
	endtask

	// ---------------------------------------------------------------
	// phase control
	// ---------------------------------------------------------------

	// nothing queued, nothing on the port, every result back, then a short drain
	task automatic wait_idle();
		while (pending_words.size() != 0 || item_valid || expected_hunks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		@(posedge clk);
		write_enable <= 1'b1;
		write_data   <= v;
		@(posedge clk);
		write_enable <= 1'b0;
		write_data   <= $urandom;
		coord_limit = v;
		@(negedge clk);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch on %s at cycle %0d: got %0h want %0h",
				what, cycle_count, got, want);
	endtask

	// ---------------------------------------------------------------
	// driver: presents queued words, holds a stalled word, predicts on accept
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_hunk(word_on_port);
				words_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					word_on_port = pending_words.pop_front();
					item_valid <= 1'b1;
					data_byte  <= word_on_port.data;
					has_byte   <= word_on_port.has;
					line_end   <= word_on_port.fin;
				end else begin
					// gap: payload is junk while valid is low
					item_valid <= 1'b0;
					data_byte  <= 8'($urandom);
					has_byte   <= 1'($urandom);
					line_end   <= 1'($urandom);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: takes results, compares with the oldest expected line
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		hunk_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_hunks.size() == 0) begin
					report_mismatch("result with no line pending", 32'(status), '0);
				end else begin
					want = expected_hunks.pop_front();
					lines_checked++;
					if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
					if (old_offset !== want.oo) report_mismatch("old_offset", old_offset, want.oo);
					if (old_count !== want.oc) report_mismatch("old_count", old_count, want.oc);
					if (new_side_offset !== want.no)
						report_mismatch("new_side_offset", new_side_offset, want.no);
					if (new_side_count !== want.nc)
						report_mismatch("new_side_count", new_side_count, want.nc);
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d lines still pending",
				cycle_count, expected_hunks.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence: reset, scripted lines at the reset limit, then random phases
	// ---------------------------------------------------------------
	initial begin
		int budget;
		clear_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// well-formed headers, counts given and left out, both end styles
		scripted_line("@@ -1,2 +3,4 @@", 1'b0);
		scripted_line("@@ -5 +7 @@ func", 1'b0);
		scripted_line("@@\t-0,0 +0,0", 1'b1);
		scripted_line("@@ -4294967295,4294967295 +4294967295,4294967295\r", 1'b0);
		scripted_line("@@ - 1 , 2 + 3 , 4 @@", 1'b0);
		scripted_line("@@ -1 +2\n", 1'b1);
		scripted_line("@@ -1 +2", 1'b1);
		// limit passed by one
		scripted_line("@@ -4294967296 +1 @@", 1'b0);
		// bad prefix
		scripted_line("diff --git", 1'b0);
		scripted_line("@@", 1'b1);
		scripted_line("@@  x", 1'b0);
		scripted_line("@ @", 1'b0);
		scripted_line("", 1'b1);
		text_buf.push_back(8'h00);
		emit_line(1'b0);
		// missing numbers and missing plus
		scripted_line("@@ - +1", 1'b0);
		scripted_line("@@ -1, +2", 1'b0);
		scripted_line("@@ -1 +2,\n", 1'b0);
		scripted_line("@@ -12 +3,,", 1'b1);
		scripted_line("@@ -1,2 3", 1'b0);
		scripted_line("@@ -1,2", 1'b1);
		// trailing junk, and bytes after a decided line
		scripted_line("@@ -1 +2 x", 1'b0);
		add_text("@@ -1 +2 ");
		text_buf.push_back(8'hFF);
		emit_line(1'b0);
		scripted_line("@@ -1 +2 @@ junk", 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_limit(limit_plan[p]);
			send_gap_pct = send_gap_plan[p % 4];
			stall_pct    = stall_plan[p % 4];
			// digit alone above a tiny limit, and two-digit overflow at nine
			if (limit_plan[p] < 10) begin
				scripted_line("@@ -3 +4", 1'b1);
				scripted_line("@@ -9 +10", 1'b0);
			end
			budget = words_planned + WORDS_PER_PHASE;
			while (words_planned < budget) begin
				build_random_line();
				emit_line($urandom_range(1));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES * 2) @(negedge clk);
		if (expected_hunks.size() != 0)
			report_mismatch("lines never reported", 32'(expected_hunks.size()), '0);

		$display("run covered %0d words and %0d line results over %0d limit settings,",
			words_taken, lines_checked, PHASES);
		$display("with sender gaps and receiver stalls mixed in, in %0d cycles", cycle_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ hunk_header_parser_unit.f @@
hw/rtl/hhp_pkg.sv
hw/rtl/hunk_header_parser_unit.sv
bench/hunk_header_parser_unit_tb.sv
